// ===== hdl/lav_pkg.sv =====
`timescale 1ns / 1ps

package lav_pkg;

    localparam int FIX_W = 32;
    localparam int DIFF_W = FIX_W + 1;
    localparam int ACC_W = 64;
    localparam int OPND_W = 33;
    localparam int MAG_W = 30;
    localparam int ROOT_W = 31;
    localparam int SQ_W = 2 * ROOT_W;
    localparam int QUEUE_DEPTH = 2;

    typedef logic signed [FIX_W-1:0] fix_t;
    typedef logic signed [DIFF_W-1:0] diff_t;

    typedef struct packed {
        fix_t eye_x;
        fix_t eye_y;
        fix_t eye_z;
        fix_t target_x;
        fix_t target_y;
        fix_t target_z;
        fix_t up_x;
        fix_t up_y;
        fix_t up_z;
    } in_item_t;

    typedef struct packed {
        logic [1:0] row_index;
        fix_t       col_x;
        fix_t       col_y;
        fix_t       col_z;
        fix_t       col_w;
        logic       degenerate;
        logic       last_row;
    } out_item_t;

    typedef struct packed {
        fix_t  [2:0] eye;
        fix_t  [2:0] up;
        diff_t [2:0] diff;
        logic        zero;
    } job_t;

    typedef struct packed {
        fix_t [2:0][3:0] ent;
        logic            degen;
    } matrix_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ABS,
        ST_SHIFT,
        ST_SQ,
        ST_SQRT_WAIT,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_RC,
        ST_UPX,
        ST_DOT,
        ST_DONE
    } back_state_t;

endpackage

// ===== hdl/lav_if.sv =====
`timescale 1ns / 1ps

interface lav_in_if import lav_pkg::*; ();
    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface lav_out_if import lav_pkg::*; ();
    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/lav_front.sv =====
`timescale 1ns / 1ps

module lav_front import lav_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    lav_in_if.sink      setup,
    output job_t        job,
    output logic        job_valid,
    input  logic        job_pop
);

    job_t       q_reg [QUEUE_DEPTH];
    logic       wr_reg;
    logic       rd_reg;
    logic [1:0] cnt_reg;
    job_t       job_new;
    logic       push;

    assign setup.ready = (cnt_reg != 2'(QUEUE_DEPTH));
    assign push = setup.valid && setup.ready;

    always_comb
    begin
        job_new.eye[0] = setup.data.eye_x;
        job_new.eye[1] = setup.data.eye_y;
        job_new.eye[2] = setup.data.eye_z;
        job_new.up[0] = setup.data.up_x;
        job_new.up[1] = setup.data.up_y;
        job_new.up[2] = setup.data.up_z;
        job_new.diff[0] = DIFF_W'(setup.data.eye_x) - DIFF_W'(setup.data.target_x);
        job_new.diff[1] = DIFF_W'(setup.data.eye_y) - DIFF_W'(setup.data.target_y);
        job_new.diff[2] = DIFF_W'(setup.data.eye_z) - DIFF_W'(setup.data.target_z);
        job_new.zero = (setup.data.eye_x == setup.data.target_x)
                    && (setup.data.eye_y == setup.data.target_y)
                    && (setup.data.eye_z == setup.data.target_z);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_reg] <= job_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= 1'b0;
            rd_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= ~wr_reg;
            end
            if (job_pop)
            begin
                rd_reg <= ~rd_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(job_pop);
        end
    end

    assign job = q_reg[rd_reg];
    assign job_valid = (cnt_reg != 2'd0);

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'(QUEUE_DEPTH))
        else $error("front queue count out of range");

endmodule

// ===== hdl/lav_sqrt.sv =====
`timescale 1ns / 1ps

module lav_sqrt import lav_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [SQ_W-1:0]   radicand,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    localparam int CNT_W = $clog2(ROOT_W);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [SQ_W-1:0]   rad_reg;
    logic [ROOT_W+1:0] rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [ROOT_W+1:0] rem_t;
    logic [ROOT_W+1:0] trial;
    logic              ge;

    assign rem_t = {rem_reg[ROOT_W-1:0], rad_reg[SQ_W-1:SQ_W-2]};
    assign trial = {root_reg, 2'b01};
    assign ge = (rem_t >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= CNT_W'(ROOT_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg <= radicand;
            rem_reg <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg <= {rad_reg[SQ_W-3:0], 2'b00};
            rem_reg <= ge ? (rem_t - trial) : rem_t;
            root_reg <= {root_reg[ROOT_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ===== hdl/lav_div.sv =====
`timescale 1ns / 1ps

module lav_div import lav_pkg::*;
#(
    parameter int NUM_W = 46
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [NUM_W-1:0]  num,
    input  logic [ROOT_W-1:0] den,
    output logic              done,
    output logic [NUM_W-1:0]  quo
);

    localparam int CNT_W = $clog2(NUM_W);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [NUM_W-1:0]  quo_reg;
    logic [ROOT_W-1:0] den_reg;
    logic [ROOT_W:0]   rem_reg;
    logic [ROOT_W:0]   rem_t;
    logic              ge;

    assign rem_t = {rem_reg[ROOT_W-1:0], num_reg[NUM_W-1]};
    assign ge = (rem_t >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= CNT_W'(NUM_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[NUM_W-2:0], 1'b0};
            rem_reg <= ge ? (rem_t - {1'b0, den_reg}) : rem_t;
            quo_reg <= {quo_reg[NUM_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo = quo_reg;

endmodule

// ===== hdl/lav_back.sv =====
`timescale 1ns / 1ps

module lav_back import lav_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  job_t    job,
    input  logic    job_valid,
    output logic    job_pop,
    output matrix_t mat,
    output logic    mat_valid,
    input  logic    mat_free
);

    localparam int NUM_W = MAG_W + FRAC_BITS;
    localparam logic signed [ACC_W-1:0] BIAS = ACC_W'((64'sd1 <<< FRAC_BITS) - 64'sd1);
    localparam logic signed [ACC_W-1:0] SAT_HI = 64'sh000000007FFFFFFF;
    localparam logic signed [ACC_W-1:0] SAT_LO = 64'shFFFFFFFF80000000;

    back_state_t state_reg;
    back_state_t state_next;

    logic [1:0] cnt_reg;
    logic [1:0] j_reg;
    logic       phase_reg;
    logic       degen_reg;
    logic       pv_reg;
    logic       psub_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] prod_reg;

    fix_t eye_reg [3];
    fix_t up_reg [3];
    fix_t fwd_reg [3];
    fix_t rgt_reg [3];
    fix_t upx_reg [3];
    fix_t tw_reg [3];
    logic signed [ACC_W-1:0] vec_reg [3];
    logic [ACC_W-1:0] mag_reg [3];
    logic             neg_reg [3];
    logic [ROOT_W-1:0] len_reg;

    logic                    mul_go;
    logic                    mul_sub;
    logic signed [OPND_W-1:0] mul_a;
    logic signed [OPND_W-1:0] mul_b;
    logic signed [ACC_W-1:0] mac_sum;
    logic                    mac_final;
    logic [1:0]              ci;
    logic [1:0]              j1;
    logic [1:0]              j2;
    logic [ACC_W-1:0]        or_mag;
    logic                    vec_zero;
    logic                    sqrt_start;
    logic                    sqrt_done;
    logic [ROOT_W-1:0]       sqrt_root;
    logic                    div_start;
    logic                    div_done;
    logic [NUM_W-1:0]        div_quo;
    logic [NUM_W-1:0]        div_num;
    fix_t                    unit_val;

    function automatic logic signed [OPND_W-1:0] ext(input fix_t v);
        ext = OPND_W'(v);
    endfunction

    function automatic logic signed [ACC_W-1:0] trunc_shift(input logic signed [ACC_W-1:0] d);
        trunc_shift = (d < 0) ? ((d + BIAS) >>> FRAC_BITS) : (d >>> FRAC_BITS);
    endfunction

    function automatic fix_t xlate(input logic signed [ACC_W-1:0] d);
        logic signed [ACC_W-1:0] t;
        t = -trunc_shift(d);
        if (t > SAT_HI)
        begin
            xlate = SAT_HI[FIX_W-1:0];
        end
        else if (t < SAT_LO)
        begin
            xlate = SAT_LO[FIX_W-1:0];
        end
        else
        begin
            xlate = t[FIX_W-1:0];
        end
    endfunction

    assign ci = (cnt_reg == 2'd3) ? 2'd0 : cnt_reg;
    assign j1 = (j_reg == 2'd2) ? 2'd0 : j_reg + 2'd1;
    assign j2 = (j_reg == 2'd0) ? 2'd2 : j_reg - 2'd1;
    assign or_mag = mag_reg[0] | mag_reg[1] | mag_reg[2];
    assign vec_zero = (vec_reg[0] == '0) && (vec_reg[1] == '0) && (vec_reg[2] == '0);
    assign mac_sum = acc_reg + (pv_reg ? (psub_reg ? -prod_reg : prod_reg) : '0);
    assign mac_final = ((state_reg == ST_SQ || state_reg == ST_DOT) && cnt_reg == 2'd3)
                    || ((state_reg == ST_RC || state_reg == ST_UPX) && cnt_reg == 2'd2);
    assign div_num = {mag_reg[j_reg][MAG_W-1:0], FRAC_BITS'(0)};
    assign unit_val = neg_reg[j_reg] ? -div_quo[FIX_W-1:0] : div_quo[FIX_W-1:0];

    lav_sqrt u_sqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (mac_sum[SQ_W-1:0]),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    lav_div #(.NUM_W(NUM_W)) u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (len_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    state_next = job.zero ? ST_DONE : ST_ABS;
                end
            end
            ST_ABS:
            begin
                state_next = vec_zero ? ST_DONE : ST_SHIFT;
            end
            ST_SHIFT:
            begin
                if ((or_mag[ACC_W-1:MAG_W] == '0) && or_mag[MAG_W-1])
                begin
                    state_next = ST_SQ;
                end
            end
            ST_SQ:
            begin
                if (mac_final)
                begin
                    state_next = ST_SQRT_WAIT;
                end
            end
            ST_SQRT_WAIT:
            begin
                if (sqrt_done)
                begin
                    state_next = ST_DIV_START;
                end
            end
            ST_DIV_START:
            begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    if (j_reg != 2'd2)
                    begin
                        state_next = ST_DIV_START;
                    end
                    else
                    begin
                        state_next = phase_reg ? ST_UPX : ST_RC;
                    end
                end
            end
            ST_RC:
            begin
                if (mac_final && j_reg == 2'd2)
                begin
                    state_next = ST_ABS;
                end
            end
            ST_UPX:
            begin
                if (mac_final && j_reg == 2'd2)
                begin
                    state_next = ST_DOT;
                end
            end
            ST_DOT:
            begin
                if (mac_final && j_reg == 2'd2)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (mat_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        mul_go = 1'b0;
        mul_sub = 1'b0;
        mul_a = '0;
        mul_b = '0;
        job_pop = 1'b0;
        sqrt_start = 1'b0;
        div_start = 1'b0;
        mat_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                job_pop = job_valid;
            end
            ST_SQ:
            begin
                mul_go = (cnt_reg != 2'd3);
                mul_a = OPND_W'(mag_reg[ci][MAG_W-1:0]);
                mul_b = OPND_W'(mag_reg[ci][MAG_W-1:0]);
                sqrt_start = mac_final;
            end
            ST_RC:
            begin
                mul_go = (cnt_reg[1] == 1'b0);
                mul_sub = cnt_reg[0];
                mul_a = ext(up_reg[cnt_reg[0] ? j2 : j1]);
                mul_b = ext(fwd_reg[cnt_reg[0] ? j1 : j2]);
            end
            ST_UPX:
            begin
                mul_go = (cnt_reg[1] == 1'b0);
                mul_sub = cnt_reg[0];
                mul_a = ext(fwd_reg[cnt_reg[0] ? j2 : j1]);
                mul_b = ext(rgt_reg[cnt_reg[0] ? j1 : j2]);
            end
            ST_DOT:
            begin
                mul_go = (cnt_reg != 2'd3);
                mul_b = ext(eye_reg[ci]);
                case (j_reg)
                    2'd0:    mul_a = ext(rgt_reg[ci]);
                    2'd1:    mul_a = ext(upx_reg[ci]);
                    default: mul_a = ext(fwd_reg[ci]);
                endcase
            end
            ST_DIV_START:
            begin
                div_start = 1'b1;
            end
            ST_DONE:
            begin
                mat_valid = 1'b1;
            end
            default:
            begin
                mul_go = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg <= 2'd0;
            j_reg <= 2'd0;
            phase_reg <= 1'b0;
            degen_reg <= 1'b0;
            pv_reg <= 1'b0;
            acc_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pv_reg <= mul_go;
            if (mac_final)
            begin
                acc_reg <= '0;
                cnt_reg <= 2'd0;
            end
            else
            begin
                acc_reg <= mac_sum;
                if (state_reg == ST_SQ || state_reg == ST_RC
                    || state_reg == ST_UPX || state_reg == ST_DOT)
                begin
                    cnt_reg <= cnt_reg + 2'd1;
                end
            end
            if (state_reg == ST_IDLE)
            begin
                j_reg <= 2'd0;
                phase_reg <= 1'b0;
                if (job_valid)
                begin
                    degen_reg <= job.zero;
                end
            end
            if (state_reg == ST_ABS && vec_zero)
            begin
                degen_reg <= 1'b1;
            end
            if (state_reg == ST_SQRT_WAIT && sqrt_done)
            begin
                j_reg <= 2'd0;
            end
            if ((state_reg == ST_DIV_WAIT && div_done) || (mac_final && state_reg != ST_SQ))
            begin
                j_reg <= (j_reg == 2'd2) ? 2'd0 : j_reg + 2'd1;
            end
            if (state_reg == ST_RC && mac_final && j_reg == 2'd2)
            begin
                phase_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mul_go)
        begin
            prod_reg <= ACC_W'(mul_a * mul_b);
            psub_reg <= mul_sub;
        end
        if (state_reg == ST_IDLE && job_valid)
        begin
            for (int i = 0; i < 3; i++)
            begin
                eye_reg[i] <= job.eye[i];
                up_reg[i] <= job.up[i];
                vec_reg[i] <= ACC_W'($signed(job.diff[i]));
            end
        end
        if (state_reg == ST_ABS)
        begin
            for (int i = 0; i < 3; i++)
            begin
                neg_reg[i] <= vec_reg[i][ACC_W-1];
                mag_reg[i] <= vec_reg[i][ACC_W-1] ? ACC_W'(-vec_reg[i]) : ACC_W'(vec_reg[i]);
            end
        end
        if (state_reg == ST_SHIFT)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (or_mag[ACC_W-1:MAG_W] != '0)
                begin
                    mag_reg[i] <= mag_reg[i] >> 1;
                end
                else if (!or_mag[MAG_W-1])
                begin
                    mag_reg[i] <= mag_reg[i] << 1;
                end
            end
        end
        if (state_reg == ST_SQRT_WAIT && sqrt_done)
        begin
            len_reg <= sqrt_root;
        end
        if (state_reg == ST_DIV_WAIT && div_done)
        begin
            if (phase_reg)
            begin
                rgt_reg[j_reg] <= unit_val;
            end
            else
            begin
                fwd_reg[j_reg] <= unit_val;
            end
        end
        if (mac_final)
        begin
            case (state_reg)
                ST_RC:   vec_reg[j_reg] <= mac_sum;
                ST_UPX:  upx_reg[j_reg] <= FIX_W'(trunc_shift(mac_sum));
                ST_DOT:  tw_reg[j_reg] <= xlate(mac_sum);
                default: len_reg <= len_reg;
            endcase
        end
    end

    always_comb
    begin
        mat.degen = degen_reg;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                mat.ent[r][c] = '0;
            end
        end
        if (!degen_reg)
        begin
            for (int c = 0; c < 3; c++)
            begin
                mat.ent[0][c] = rgt_reg[c];
                mat.ent[1][c] = upx_reg[c];
                mat.ent[2][c] = fwd_reg[c];
            end
            mat.ent[0][3] = tw_reg[0];
            mat.ent[1][3] = tw_reg[1];
            mat.ent[2][3] = tw_reg[2];
        end
    end

    a_done_leaves: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && mat_free) |=> (state_reg == ST_IDLE))
        else $error("finished matrix not released after handoff");

    a_sqrt_wait: assert property (@(posedge clk) disable iff (!rst_n)
        sqrt_start |=> (state_reg == ST_SQRT_WAIT))
        else $error("square root started outside its wait");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |-> (job_valid && state_reg == ST_IDLE))
        else $error("job popped while engine busy or queue empty");

endmodule

// ===== hdl/lav_emit.sv =====
`timescale 1ns / 1ps

module lav_emit import lav_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  matrix_t mat,
    input  logic    mat_valid,
    output logic    mat_free,
    lav_out_if.source rows
);

    localparam fix_t ONE = fix_t'(64'sd1 <<< FRAC_BITS);

    matrix_t    mat_reg;
    logic       busy_reg;
    logic [1:0] row_reg;
    logic       beat;
    logic       load;

    assign beat = rows.valid && rows.ready;
    assign mat_free = !busy_reg || (beat && row_reg == 2'd3);
    assign load = mat_valid && mat_free;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            mat_reg <= mat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            row_reg <= 2'd0;
        end
        else
        begin
            if (load)
            begin
                busy_reg <= 1'b1;
                row_reg <= 2'd0;
            end
            else if (beat)
            begin
                row_reg <= row_reg + 2'd1;
                if (row_reg == 2'd3)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        rows.valid = busy_reg;
        rows.data.row_index = row_reg;
        rows.data.degenerate = mat_reg.degen;
        rows.data.last_row = (row_reg == 2'd3);
        if (row_reg == 2'd3)
        begin
            rows.data.col_x = '0;
            rows.data.col_y = '0;
            rows.data.col_z = '0;
            rows.data.col_w = ONE;
        end
        else
        begin
            rows.data.col_x = mat_reg.ent[row_reg][0];
            rows.data.col_y = mat_reg.ent[row_reg][1];
            rows.data.col_z = mat_reg.ent[row_reg][2];
            rows.data.col_w = mat_reg.ent[row_reg][3];
        end
    end

    a_row_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !beat) |=> $stable(row_reg))
        else $error("row counter moved without a beat");

endmodule

// ===== hdl/look_at_view_matrix_top.sv =====
// Look-at view matrix generator, signed fixed point with FRAC_BITS fraction bits.
// The setup channel takes one camera setup per beat: eye, target and world-up vectors.
// The rows channel returns four beats per setup, rows 0 to 3 in order, with last_row
// set on row 3 and degenerate set on all four when an axis had zero length.
// A two-entry queue in the front lets two further setups be taken while one is
// being worked on, so the setup side rarely waits on the row side.
// The back end works one setup at a time through a shared multiplier-accumulator,
// a bit-serial square root and a bit-serial divider (three quotients per axis).
// Both normalizations use them. The vector is shifted into range before its square
// root; a setup with eye equal to target skips the arithmetic and goes straight
// to its degenerate matrix. Rows are held in an output register: a stalled receiver
// keeps the current row steady, and the back end finishes the next matrix and waits.
// Reset is asynchronous and active low; it empties the queue and idles all units.
`timescale 1ns / 1ps

module look_at_view_matrix_top import lav_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    lav_in_if.sink    setup,
    lav_out_if.source rows
);

    job_t    job;
    logic    job_valid;
    logic    job_pop;
    matrix_t mat;
    logic    mat_valid;
    logic    mat_free;

    lav_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .setup     (setup),
        .job       (job),
        .job_valid (job_valid),
        .job_pop   (job_pop)
    );

    lav_back #(.FRAC_BITS(FRAC_BITS)) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (job),
        .job_valid (job_valid),
        .job_pop   (job_pop),
        .mat       (mat),
        .mat_valid (mat_valid),
        .mat_free  (mat_free)
    );

    lav_emit #(.FRAC_BITS(FRAC_BITS)) u_emit
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .mat       (mat),
        .mat_valid (mat_valid),
        .mat_free  (mat_free),
        .rows      (rows)
    );

endmodule
